[rtl/core/elevator_call_table_dispatch_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the elevator call table dispatch block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ELEVATOR_CALL_TABLE_DISPATCH_ASSERT_SVH
`define ELEVATOR_CALL_TABLE_DISPATCH_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ECTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ECTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ectd_pkg.sv]
// ---------------------------------------------------------------------------
// ectd_pkg
// Shared types and codes of the elevator call table dispatch block.
// ---------------------------------------------------------------------------
`default_nettype none

package ectd_pkg;

	// default number of floors kept in the call table
	localparam int FLOORS_DEF = 4;

	// fixed field widths
	localparam int FLOOR_W  = 4;
	localparam int CUR_W    = 5;
	localparam int LAMP_W   = 12;
	localparam int LAMP_FLR = 4;
	localparam int S_DATA_W = 16;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		OP_ADD       = 2'd0,
		OP_CLR_FLOOR = 2'd1,
		OP_CLR_ALL   = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BTN_UP   = 2'd0,
		BTN_DOWN = 2'd1,
		BTN_CAB  = 2'd2,
		BTN_BAD  = 2'd3
	} btn_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2,
		DIR_BAD  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		STAT_FOUND    = 2'd0,
		STAT_NONE     = 2'd1,
		STAT_BAD_FLR  = 2'd2,
		STAT_BAD_DIR  = 2'd3
	} stat_t;

	// command from controller to datapath
	typedef struct packed {
		logic take;   // accept the input word and load the result register
	} ectd_cmd_t;

endpackage

`default_nettype wire

[rtl/core/ectd_ctrl.sv]
// ---------------------------------------------------------------------------
// ectd_ctrl
// Handshake controller: tracks whether the result register holds a word.
// ---------------------------------------------------------------------------
`default_nettype none

module ectd_ctrl
	import ectd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ectd_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_EMPTY = 2'b01,
		S_FULL  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// take a new word when the result register is empty or drains now
	assign in_ready  = (state_q == S_EMPTY) || out_ready;
	assign out_valid = (state_q == S_FULL);
	assign cmd.take  = in_valid && in_ready;

	// advance the occupancy state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_EMPTY: begin
				if (cmd.take) state_nxt = S_FULL;
			end
			S_FULL: begin
				if (cmd.take) state_nxt = S_FULL;
				else if (out_ready) state_nxt = S_EMPTY;
			end
			default: state_nxt = S_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_EMPTY;
		else state_q <= state_nxt;
	end

endmodule

`default_nettype wire

[rtl/core/ectd_datapath.sv]
// ---------------------------------------------------------------------------
// ectd_datapath
// Call table, directional floor scan and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ectd_datapath
	import ectd_pkg::*;
#(
	parameter int FLOORS = FLOORS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ectd_cmd_t          cmd,
	input  wire op_t                opcode,
	input  wire logic [FLOOR_W-1:0] floor,
	input  wire btn_t               button,
	input  wire logic [CUR_W-1:0]   current_floor,
	input  wire dir_t               direction,
	output logic [FLOOR_W-1:0]      target_floor,
	output stat_t                   status,
	output logic [LAMP_W-1:0]       lamps
);

	localparam int LAMP_FLOORS = (FLOORS < LAMP_FLR) ? FLOORS : LAMP_FLR;

	logic [2:0] calls_q   [FLOORS];
	logic [2:0] calls_nxt [FLOORS];

	logic               floor_ok;
	logic               cur_ok;
	logic [FLOOR_W-1:0] cur_idx;

	logic               up_hit, dn_hit, st1_hit, st2_hit;
	logic [FLOOR_W-1:0] up_idx, dn_idx, st1_idx, st2_idx;

	logic [FLOOR_W-1:0] target_nxt;
	stat_t              status_nxt;
	logic [LAMP_W-1:0]  lamps_nxt;

	logic [FLOOR_W-1:0] target_q;
	stat_t              status_q;
	logic [LAMP_W-1:0]  lamps_q;

	assign floor_ok = {1'b0, floor} < (FLOOR_W+1)'(FLOORS);
	assign cur_ok   = !current_floor[CUR_W-1] &&
		({1'b0, current_floor[FLOOR_W-1:0]} < (FLOOR_W+1)'(FLOORS));
	assign cur_idx  = current_floor[FLOOR_W-1:0];

	// apply add, clear floor or clear all to the table
	always_comb begin
		for (int f = 0; f < FLOORS; f++) begin
			calls_nxt[f] = calls_q[f];
			case (opcode)
				OP_ADD: begin
					if (floor_ok && (button != BTN_BAD) && (floor == FLOOR_W'(f)))
						calls_nxt[f][button] = 1'b1;
				end
				OP_CLR_FLOOR: begin
					if (floor_ok && (floor == FLOOR_W'(f))) calls_nxt[f] = 3'b000;
				end
				OP_CLR_ALL: calls_nxt[f] = 3'b000;
				default: calls_nxt[f] = calls_q[f];
			endcase
		end
	end

	// priority-encode the directional scans over the floors
	always_comb begin
		up_hit  = 1'b0;
		up_idx  = '0;
		dn_hit  = 1'b0;
		dn_idx  = '0;
		st1_hit = 1'b0;
		st1_idx = '0;
		st2_hit = 1'b0;
		st2_idx = '0;
		// lowest floor at or above the car
		for (int f = FLOORS - 1; f >= 0; f--) begin
			if ((FLOOR_W'(f) >= cur_idx) && (calls_q[f][BTN_UP] || calls_q[f][BTN_CAB] ||
				((f == FLOORS - 1) && calls_q[f][BTN_DOWN]))) begin
				up_hit = 1'b1;
				up_idx = FLOOR_W'(f);
			end
		end
		// highest floor at or below the car
		for (int f = 0; f < FLOORS; f++) begin
			if ((FLOOR_W'(f) <= cur_idx) && (calls_q[f][BTN_DOWN] || calls_q[f][BTN_CAB] ||
				((f == 0) && calls_q[f][BTN_UP]))) begin
				dn_hit = 1'b1;
				dn_idx = FLOOR_W'(f);
			end
		end
		// stopped car: lowest up or cab call, else highest down or cab call
		for (int f = FLOORS - 1; f >= 0; f--) begin
			if (calls_q[f][BTN_UP] || calls_q[f][BTN_CAB]) begin
				st1_hit = 1'b1;
				st1_idx = FLOOR_W'(f);
			end
		end
		for (int f = 0; f < FLOORS; f++) begin
			if (calls_q[f][BTN_DOWN] || calls_q[f][BTN_CAB]) begin
				st2_hit = 1'b1;
				st2_idx = FLOOR_W'(f);
			end
		end
	end

	// select target and status
	always_comb begin
		target_nxt = '0;
		status_nxt = STAT_FOUND;
		if (opcode == OP_QUERY) begin
			if (!cur_ok) begin
				status_nxt = STAT_BAD_FLR;
			end else begin
				case (direction)
					DIR_UP: begin
						status_nxt = up_hit ? STAT_FOUND : STAT_NONE;
						target_nxt = up_hit ? up_idx : '0;
					end
					DIR_DOWN: begin
						status_nxt = dn_hit ? STAT_FOUND : STAT_NONE;
						target_nxt = dn_hit ? dn_idx : '0;
					end
					DIR_STOP: begin
						if (st1_hit) begin
							target_nxt = st1_idx;
						end else if (st2_hit) begin
							target_nxt = st2_idx;
						end else begin
							status_nxt = STAT_NONE;
						end
					end
					default: status_nxt = STAT_BAD_DIR;
				endcase
			end
		end
	end

	// lamp vector mirrors the table after the operation
	always_comb begin
		lamps_nxt = '0;
		for (int f = 0; f < LAMP_FLOORS; f++) begin
			lamps_nxt[3*f +: 3] = calls_nxt[f];
		end
	end

	// hold the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < FLOORS; f++) calls_q[f] <= 3'b000;
		end else if (cmd.take) begin
			for (int f = 0; f < FLOORS; f++) calls_q[f] <= calls_nxt[f];
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			target_q <= target_nxt;
			status_q <= status_nxt;
			lamps_q  <= lamps_nxt;
		end
	end

	assign target_floor = target_q;
	assign status       = status_q;
	assign lamps        = lamps_q;

endmodule

`default_nettype wire

[rtl/core/elevator_call_table_dispatch.sv]
// ---------------------------------------------------------------------------
// elevator_call_table_dispatch
// Pending elevator call table with directional next-target dispatch.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word: tuser is the opcode (add call, clear
//   floor, clear all, query), tdata the floor, button, current floor and
//   direction. Every accepted word yields exactly one m_axis word with the
//   target floor and lamp vector in tdata and the status code in tuser.
//   The result word shows on m_axis in the cycle after acceptance.
//   Throughput is one word per cycle while m_axis_tready stays high; the
//   table update and the floor scan are combinational ahead of the result
//   register. When the receiver stalls, the result word holds and
//   s_axis_tready stays high until the register is full; it then follows
//   m_axis_tready. Reset empties the call table and marks the result
//   register empty; the block takes words as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module elevator_call_table_dispatch
	import ectd_pkg::*;
#(
	parameter int FLOORS = FLOORS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// [3:0] floor, [5:4] button, [10:6] current_floor, [12:11] direction
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,
	// [1:0] opcode
	input  wire logic [S_USER_W-1:0] s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [3:0] target_floor, [15:4] lamps
	output logic [M_DATA_W-1:0]      m_axis_tdata,
	// [1:0] status
	output logic [M_USER_W-1:0]      m_axis_tuser
);

	ectd_cmd_t          cmd;
	logic [FLOOR_W-1:0] target_floor;
	stat_t              status;
	logic [LAMP_W-1:0]  lamps;

	ectd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ectd_datapath #(
		.FLOORS (FLOORS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (op_t'(s_axis_tuser[1:0])),
		.floor         (s_axis_tdata[3:0]),
		.button        (btn_t'(s_axis_tdata[5:4])),
		.current_floor (s_axis_tdata[10:6]),
		.direction     (dir_t'(s_axis_tdata[12:11])),
		.target_floor  (target_floor),
		.status        (status),
		.lamps         (lamps)
	);

	assign m_axis_tdata = {lamps, target_floor};
	assign m_axis_tuser = status;

endmodule

`default_nettype wire

[rtl/core/ectd_checker.sv]
// ---------------------------------------------------------------------------
// ectd_checker
// Port-level checks of the call table dispatch block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "elevator_call_table_dispatch_assert.svh"

module ectd_checker
	import ectd_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic [S_DATA_W-1:0] s_axis_tdata,
	input wire logic [S_USER_W-1:0] s_axis_tuser,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [M_DATA_W-1:0] m_axis_tdata,
	input wire logic [M_USER_W-1:0] m_axis_tuser
);

	// a stalled result word stays offered
	`ECTD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")

	// every accepted word gives a result in the next cycle
	`ECTD_ASSERT_NEXT(a_one_cycle, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "no result one cycle after accept")

	// an empty result register never blocks the input
	`ECTD_ASSERT_SAME(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input blocked with empty result register")

	// table commands report found with target floor zero
	`ECTD_ASSERT_NEXT(a_cmd_status, s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_QUERY), (m_axis_tuser == STAT_FOUND) && (m_axis_tdata[3:0] == 4'd0), "bad status for table command")

endmodule

bind elevator_call_table_dispatch ectd_checker u_ectd_checker (.*);

`default_nettype wire

[tb/sv/ectd_checker.sv]
// ---------------------------------------------------------------------------
// ectd_scoreboard
// Watches both stream channels of the call table dispatch block, keeps its
// own copy of the call table, predicts one result word per accepted command
// word and compares the result words field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module ectd_scoreboard
	import ectd_pkg::*;
#(
	parameter int FLOORS = FLOORS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	input  wire logic                s_axis_tready,
	// [3:0] floor, [5:4] button, [10:6] current_floor, [12:11] direction
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,
	// [1:0] opcode
	input  wire logic [S_USER_W-1:0] s_axis_tuser,
	input  wire logic                m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [3:0] target_floor, [15:4] lamps
	input  wire logic [M_DATA_W-1:0] m_axis_tdata,
	// [1:0] status
	input  wire logic [M_USER_W-1:0] m_axis_tuser,
	output int                       errors,
	output int                       outstanding,
	output int                       results
);

	typedef struct {
		logic [FLOOR_W-1:0] target;
		stat_t              status;
		logic [LAMP_W-1:0]  lamps;
	} dispatch_word_t;

	// bit 0 hall up, bit 1 hall down, bit 2 cab
	logic [2:0]     call_table [FLOORS];
	dispatch_word_t due_words [$];
	int             fail_count = 0;
	int             due_count  = 0;
	int             seen_count = 0;

	assign errors      = fail_count;
	assign outstanding = due_count;
	assign results     = seen_count;

	initial begin
		for (int f = 0; f < FLOORS; f++) call_table[f] = 3'b000;
	end

	task automatic report(input string what);
		if (fail_count < 40) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		fail_count++;
	endtask

	// Pick the next stop for a query against the current table.
	function automatic void next_stop(input logic signed [CUR_W-1:0] cur, input dir_t dir,
		output logic [FLOOR_W-1:0] target, output stat_t status);
		int  c;
		int  f;
		bit  hit;
		c      = cur;
		hit    = 1'b0;
		target = '0;
		status = STAT_NONE;
		if (c < 0 || c >= FLOORS) begin
			status = STAT_BAD_FLR;
		end else if (dir == DIR_BAD) begin
			status = STAT_BAD_DIR;
		end else begin
			case (dir)
				DIR_UP: begin
					for (f = c; f < FLOORS; f++) begin
						if (!hit && (call_table[f][BTN_UP] || call_table[f][BTN_CAB] ||
								(f == FLOORS - 1 && call_table[f][BTN_DOWN]))) begin
							hit    = 1'b1;
							target = FLOOR_W'(f);
						end
					end
				end
				DIR_DOWN: begin
					for (f = c; f >= 0; f--) begin
						if (!hit && (call_table[f][BTN_DOWN] || call_table[f][BTN_CAB] ||
								(f == 0 && call_table[f][BTN_UP]))) begin
							hit    = 1'b1;
							target = FLOOR_W'(f);
						end
					end
				end
				default: begin
					// stopped: up-or-cab from the bottom, then down-or-cab from the top
					for (f = 0; f < FLOORS; f++) begin
						if (!hit && (call_table[f][BTN_UP] || call_table[f][BTN_CAB])) begin
							hit    = 1'b1;
							target = FLOOR_W'(f);
						end
					end
					for (f = FLOORS - 1; f >= 0; f--) begin
						if (!hit && (call_table[f][BTN_DOWN] || call_table[f][BTN_CAB])) begin
							hit    = 1'b1;
							target = FLOOR_W'(f);
						end
					end
				end
			endcase
			if (hit) status = STAT_FOUND;
		end
	endfunction

	// Apply one command word to the table and form its result word.
	function automatic dispatch_word_t dispatch(input logic [S_DATA_W-1:0] data,
		input logic [S_USER_W-1:0] user);
		dispatch_word_t            r;
		op_t                       op;
		logic [FLOOR_W-1:0]        fl;
		btn_t                      btn;
		logic signed [CUR_W-1:0]   cur;
		dir_t                      dir;
		op     = op_t'(user);
		fl     = data[3:0];
		btn    = btn_t'(data[5:4]);
		cur    = data[10:6];
		dir    = dir_t'(data[12:11]);
		r.target = '0;
		r.status = STAT_FOUND;
		r.lamps  = '0;
		case (op)
			OP_ADD: begin
				if (fl < FLOORS && btn != BTN_BAD) call_table[fl][btn] = 1'b1;
			end
			OP_CLR_FLOOR: begin
				if (fl < FLOORS) call_table[fl] = 3'b000;
			end
			OP_CLR_ALL: begin
				for (int f = 0; f < FLOORS; f++) call_table[f] = 3'b000;
			end
			default: begin
				next_stop(cur, dir, r.target, r.status);
			end
		endcase
		for (int f = 0; f < FLOORS && f < LAMP_FLR; f++) r.lamps[3*f +: 3] = call_table[f];
		return r;
	endfunction

	// Compare the result word first, then queue the prediction for the command word.
	always @(posedge clk) begin
		dispatch_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_count <= seen_count + 1;
				if (due_words.size() == 0) begin
					report("result word with no command word waiting");
				end else begin
					want = due_words.pop_front();
					if (m_axis_tdata[3:0] !== want.target)
						report($sformatf("target_floor %0d, want %0d",
							m_axis_tdata[3:0], want.target));
					if (m_axis_tuser !== want.status)
						report($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
					if (m_axis_tdata[15:4] !== want.lamps)
						report($sformatf("lamps %03h, want %03h",
							m_axis_tdata[15:4], want.lamps));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				due_words.push_back(dispatch(s_axis_tdata, s_axis_tuser));
			end
			due_count <= due_words.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the elevator call table dispatch block: a directed
// set of corner commands, then random call sequences under three idling
// phases on both channels; checking is done by ectd_scoreboard.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	import ectd_pkg::*;

	localparam int FLOORS   = FLOORS_DEF;
	localparam int PER_PASS = 615;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [S_USER_W-1:0] s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [M_USER_W-1:0] m_axis_tuser;

	int errors;
	int outstanding;
	int results;
	int snd_idle = 0;
	int rcv_idle = 0;
	int op_count [4] = '{default: 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	elevator_call_table_dispatch #(.FLOORS(FLOORS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	ectd_scoreboard #(.FLOORS(FLOORS)) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.outstanding   (outstanding),
		.results       (results)
	);

	// Stall the result channel at random.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);
	end

	// Offer one command word after random idle cycles and hold it until taken.
	task automatic send_word(input op_t op, input logic [3:0] fl, input logic [1:0] btn,
		input logic [4:0] cur, input logic [1:0] dir);
		while ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b000, dir, cur, btn, fl};
		op_count[op]++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic add_call(input int fl, input btn_t btn);
		send_word(OP_ADD, fl[3:0], btn, 5'd0, DIR_STOP);
	endtask

	task automatic ask_target(input int cur, input dir_t dir);
		send_word(OP_QUERY, 4'd0, BTN_UP, cur[4:0], dir);
	endtask

	// Hold off the sender until every expected result word has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Mostly well-formed commands; the rest keep all fields fully random.
	task automatic random_word();
		op_t        op;
		logic [3:0] fl;
		logic [1:0] btn;
		logic [4:0] cur;
		logic [1:0] dir;
		int         pick;
		op   = op_t'($urandom_range(3));
		fl   = 4'($urandom);
		btn  = 2'($urandom);
		cur  = 5'($urandom);
		dir  = 2'($urandom);
		pick = $urandom_range(99);
		if (pick >= 10) begin
			if (pick < 48) begin
				op  = OP_ADD;
				fl  = 4'($urandom_range(FLOORS - 1));
				btn = 2'($urandom_range(2));
			end else if (pick < 60) begin
				op = OP_CLR_FLOOR;
				fl = 4'($urandom_range(FLOORS - 1));
			end else if (pick < 63) begin
				op = OP_CLR_ALL;
			end else begin
				op  = OP_QUERY;
				cur = 5'($urandom_range(FLOORS - 1));
				dir = 2'($urandom_range(2));
			end
		end
		send_word(op, fl, btn, cur, dir);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int pass = 0; pass < 3; pass++) begin
			snd_idle = (pass == 0) ? 38 : (pass == 1) ? 50 : 0;
			rcv_idle <= (pass == 0) ? 50 : (pass == 1) ? 38 : 0;

			if (pass == 0) begin
				// empty table, then the ignored adds
				ask_target(0, DIR_STOP);
				add_call(15, BTN_UP);
				add_call(FLOORS, BTN_CAB);
				add_call(1, BTN_BAD);
				ask_target(1, DIR_UP);
				// top floor hall down taken while moving up
				add_call(FLOORS - 1, BTN_DOWN);
				ask_target(1, DIR_UP);
				ask_target(FLOORS - 1, DIR_DOWN);
				ask_target(0, DIR_STOP);
				// bottom floor hall up taken while moving down
				send_word(OP_CLR_ALL, 4'd0, BTN_UP, 5'd0, DIR_STOP);
				add_call(0, BTN_UP);
				ask_target(FLOORS - 1, DIR_DOWN);
				add_call(2, BTN_CAB);
				add_call(1, BTN_DOWN);
				ask_target(0, DIR_UP);
				ask_target(0, DIR_STOP);
				// bad current floor wins over bad direction
				ask_target(-1, DIR_BAD);
				ask_target(-16, DIR_UP);
				ask_target(FLOORS, DIR_DOWN);
				ask_target(15, DIR_STOP);
				ask_target(2, DIR_BAD);
				// ignored and real floor clears, then a full clear
				send_word(OP_CLR_FLOOR, 4'd15, BTN_UP, 5'd0, DIR_STOP);
				send_word(OP_CLR_FLOOR, 4'd2, BTN_UP, 5'd0, DIR_STOP);
				ask_target(3, DIR_DOWN);
				send_word(OP_CLR_ALL, 4'hF, BTN_BAD, 5'h1F, DIR_BAD);
				ask_target(0, DIR_STOP);
				drain();
			end

			for (int i = 0; i < PER_PASS; i++) begin
				random_word();
				if (i % 300 == 150) drain();
			end
			drain();
		end

		repeat (5) @(posedge clk);
		$display("Covered %0d command words (add %0d, clear floor %0d, clear all %0d, query %0d),",
			op_count[OP_ADD] + op_count[OP_CLR_FLOOR] + op_count[OP_CLR_ALL] +
			op_count[OP_QUERY], op_count[OP_ADD], op_count[OP_CLR_FLOOR],
			op_count[OP_CLR_ALL], op_count[OP_QUERY]);
		$display("%0d result words checked across three idling phases, %0d mismatches.",
			results, errors);
		if (errors == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#2000000;
		$display("Timeout with %0d result words outstanding", outstanding);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
